// File: rtl/dsfl_pkg.sv
// shared types and constants for the dds serial frequency loader
`default_nettype none

package dsfl_pkg;

    localparam int unsigned REF_CLOCK_HZ_DEFAULT = 125000000;

    localparam int unsigned FREQ_W     = 26;
    localparam int unsigned WORD_W     = 32;
    localparam int unsigned CTRL_BITS  = 8;
    localparam int unsigned LOAD_LEN   = WORD_W + CTRL_BITS + 1;
    localparam int unsigned STEP_W     = $clog2(LOAD_LEN);
    localparam int unsigned BIT_IDX_W  = $clog2(WORD_W);
    localparam int unsigned QUEUE_DEPTH = 2;

    // reset start-up sequence positions
    localparam logic [STEP_W-1:0] RST_STEP_PULSE  = STEP_W'(0);
    localparam logic [STEP_W-1:0] RST_STEP_WCLK   = STEP_W'(1);
    localparam logic [STEP_W-1:0] RST_STEP_UPDATE = STEP_W'(2);

    // load sequence boundaries
    localparam logic [STEP_W-1:0] LOAD_CTRL_START = STEP_W'(WORD_W);
    localparam logic [STEP_W-1:0] LOAD_UPDATE     = STEP_W'(WORD_W + CTRL_BITS);

    typedef enum logic [1:0] {
        STROBE_WCLK = 2'd0,
        STROBE_FQUD = 2'd1,
        STROBE_RST  = 2'd2
    } strobe_t;

    typedef enum logic [0:0] {
        ACT_LOAD  = 1'b0,
        ACT_RESET = 1'b1
    } action_t;

    typedef enum logic [2:0] {
        FRONT_IDLE  = 3'd0,
        FRONT_SCALE = 3'd1,
        FRONT_EST   = 3'd2,
        FRONT_CHECK = 3'd3,
        FRONT_FIX   = 3'd4,
        FRONT_PUSH  = 3'd5
    } front_state_t;

    typedef struct packed {
        logic              is_reset;
        logic [WORD_W-1:0] word;
    } entry_t;

endpackage

`default_nettype wire

// File: rtl/dsfl_front.sv
// front end: takes requests, saturates and divides a load's frequency into a tuning word
`default_nettype none

module dsfl_front #(
    parameter int unsigned REF_CLOCK_HZ = dsfl_pkg::REF_CLOCK_HZ_DEFAULT
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output      logic                        in_ready,
    input  wire logic                        in_action,
    input  wire logic [dsfl_pkg::FREQ_W-1:0] in_freq,
    output      logic                        push_valid,
    input  wire logic                        push_ready,
    output      dsfl_pkg::entry_t            push_entry
);

    localparam int unsigned RW        = $clog2(REF_CLOCK_HZ);
    localparam int unsigned PW        = RW + dsfl_pkg::WORD_W;
    localparam int unsigned HALF      = REF_CLOCK_HZ / 2;
    localparam logic [RW:0] REF_CONST = (RW + 1)'(REF_CLOCK_HZ);
    // 2^(32+RW) / ref lies in [2^32, 2^33); only the part above 2^32 is multiplied
    localparam logic [dsfl_pkg::WORD_W-1:0] RECIP_FRAC = dsfl_pkg::WORD_W'(
        ((64'd1 << (dsfl_pkg::WORD_W + RW)) / 64'(REF_CLOCK_HZ)) -
        (64'd1 << dsfl_pkg::WORD_W));

    dsfl_pkg::front_state_t state_reg, state_next;
    logic [RW-1:0]                     freq_reg, freq_next;
    logic [PW-1:0]                     prod_reg, prod_next;
    logic [dsfl_pkg::WORD_W-1:0]       quo_reg, quo_next;
    logic [RW:0]                       chk_reg, chk_next;
    logic                              act_reg, act_next;

    logic                 accept;
    logic [31:0]          freq_ext;
    logic [31:0]          freq_sat;
    logic [PW-1:0]        est_sum;
    logic [RW:0]          rem;
    logic                 rem_ge;

    assign accept    = in_valid && in_ready;
    assign freq_ext  = 32'(in_freq);
    assign freq_sat  = (freq_ext > HALF) ? 32'(HALF) : freq_ext;
    // f * 2^32 + f * frac is f times the reciprocal, a low estimate by less than one
    assign est_sum   = {freq_reg, dsfl_pkg::WORD_W'(0)} + prod_reg;
    // f * 2^32 has zero low bits and the true remainder is below twice the reference
    assign rem       = {(RW + 1){1'b0}} - chk_reg;
    assign rem_ge    = (rem >= REF_CONST);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            dsfl_pkg::FRONT_IDLE:
            begin
                if (accept)
                begin
                    state_next = (in_action == dsfl_pkg::ACT_RESET) ?
                                 dsfl_pkg::FRONT_PUSH : dsfl_pkg::FRONT_SCALE;
                end
            end
            dsfl_pkg::FRONT_SCALE:
            begin
                state_next = dsfl_pkg::FRONT_EST;
            end
            dsfl_pkg::FRONT_EST:
            begin
                state_next = dsfl_pkg::FRONT_CHECK;
            end
            dsfl_pkg::FRONT_CHECK:
            begin
                state_next = dsfl_pkg::FRONT_FIX;
            end
            dsfl_pkg::FRONT_FIX:
            begin
                state_next = dsfl_pkg::FRONT_PUSH;
            end
            dsfl_pkg::FRONT_PUSH:
            begin
                if (accept)
                begin
                    state_next = (in_action == dsfl_pkg::ACT_RESET) ?
                                 dsfl_pkg::FRONT_PUSH : dsfl_pkg::FRONT_SCALE;
                end
                else if (push_ready)
                begin
                    state_next = dsfl_pkg::FRONT_IDLE;
                end
            end
            default:
            begin
                state_next = dsfl_pkg::FRONT_IDLE;
            end
        endcase
    end

    // outputs and datapath
    always_comb
    begin
        in_ready   = 1'b0;
        push_valid = 1'b0;
        freq_next  = freq_reg;
        prod_next  = prod_reg;
        quo_next   = quo_reg;
        chk_next   = chk_reg;
        act_next   = act_reg;
        case (state_reg)
            dsfl_pkg::FRONT_IDLE:
            begin
                in_ready = 1'b1;
            end
            dsfl_pkg::FRONT_SCALE:
            begin
                prod_next = PW'(freq_reg) * PW'(RECIP_FRAC);
            end
            dsfl_pkg::FRONT_EST:
            begin
                quo_next = est_sum[PW-1:RW];
            end
            dsfl_pkg::FRONT_CHECK:
            begin
                chk_next = quo_reg[RW:0] * REF_CONST;
            end
            dsfl_pkg::FRONT_FIX:
            begin
                // estimate is at most one short
                quo_next = quo_reg + dsfl_pkg::WORD_W'(rem_ge);
            end
            dsfl_pkg::FRONT_PUSH:
            begin
                push_valid = 1'b1;
                in_ready   = push_ready;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
        if (accept)
        begin
            freq_next = freq_sat[RW-1:0];
            quo_next  = '0;
            act_next  = in_action;
        end
    end

    assign push_entry.is_reset = act_reg;
    assign push_entry.word     = quo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= dsfl_pkg::FRONT_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        freq_reg <= freq_next;
        prod_reg <= prod_next;
        quo_reg  <= quo_next;
        chk_reg  <= chk_next;
        act_reg  <= act_next;
    end

endmodule

`default_nettype wire

// File: rtl/dsfl_queue.sv
// short queue between the divider and the serialiser
`default_nettype none

module dsfl_queue (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             wr_valid,
    output      logic             wr_ready,
    input  wire dsfl_pkg::entry_t wr_entry,
    output      logic             rd_valid,
    input  wire logic             rd_ready,
    output      dsfl_pkg::entry_t rd_entry
);

    localparam int unsigned PTR_W = $clog2(dsfl_pkg::QUEUE_DEPTH);
    localparam int unsigned CNT_W = $clog2(dsfl_pkg::QUEUE_DEPTH + 1);

    dsfl_pkg::entry_t  slot_reg [dsfl_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;
    logic              do_wr;
    logic              do_rd;

    assign wr_ready = (count_reg != CNT_W'(dsfl_pkg::QUEUE_DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_entry = slot_reg[rd_ptr_reg];
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_valid && rd_ready;

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wr_ptr_reg] <= wr_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(dsfl_pkg::QUEUE_DEPTH - 1)) ?
                              '0 : wr_ptr_reg + 1'b1;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(dsfl_pkg::QUEUE_DEPTH - 1)) ?
                              '0 : rd_ptr_reg + 1'b1;
            end
            if (do_wr && !do_rd)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_rd && !do_wr)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// File: rtl/dsfl_back.sv
// back end: serialises a queued word or reset sequence into strobe events
`default_nettype none

module dsfl_back (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             q_valid,
    output      logic             q_ready,
    input  wire dsfl_pkg::entry_t q_entry,
    output      logic             out_valid,
    input  wire logic             out_ready,
    output      logic             out_bit,
    output      logic [1:0]       out_strobe,
    output      logic             out_last
);

    dsfl_pkg::entry_t              entry_reg;
    logic                          busy_reg;
    logic [dsfl_pkg::STEP_W-1:0]   step_reg;
    logic                          valid_reg;
    logic                          bit_reg;
    dsfl_pkg::strobe_t             strobe_reg;
    logic                          last_reg;

    logic              advance;
    logic              emit;
    logic              cur_bit;
    dsfl_pkg::strobe_t cur_strobe;
    logic              cur_last;

    assign advance = !valid_reg || out_ready;
    assign emit    = busy_reg && advance;
    assign q_ready = !busy_reg || (emit && cur_last);

    always_comb
    begin
        cur_bit    = 1'b0;
        cur_strobe = dsfl_pkg::STROBE_WCLK;
        cur_last   = 1'b0;
        if (entry_reg.is_reset)
        begin
            case (step_reg)
                dsfl_pkg::RST_STEP_PULSE:
                begin
                    cur_strobe = dsfl_pkg::STROBE_RST;
                end
                dsfl_pkg::RST_STEP_WCLK:
                begin
                    cur_strobe = dsfl_pkg::STROBE_WCLK;
                end
                default:
                begin
                    cur_strobe = dsfl_pkg::STROBE_FQUD;
                    cur_last   = 1'b1;
                end
            endcase
        end
        else if (step_reg < dsfl_pkg::LOAD_CTRL_START)
        begin
            // word bits, least significant first
            cur_bit = entry_reg.word[step_reg[dsfl_pkg::BIT_IDX_W-1:0]];
        end
        else if (step_reg >= dsfl_pkg::LOAD_UPDATE)
        begin
            cur_strobe = dsfl_pkg::STROBE_FQUD;
            cur_last   = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            step_reg  <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                valid_reg <= busy_reg;
            end
            if (q_valid && q_ready)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (emit)
            begin
                if (cur_last)
                begin
                    busy_reg <= 1'b0;
                end
                else
                begin
                    step_reg <= step_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_valid && q_ready)
        begin
            entry_reg <= q_entry;
        end
        if (emit)
        begin
            bit_reg    <= cur_bit;
            strobe_reg <= cur_strobe;
            last_reg   <= cur_last;
        end
    end

    assign out_valid  = valid_reg;
    assign out_bit    = bit_reg;
    assign out_strobe = strobe_reg;
    assign out_last   = last_reg;

endmodule

`default_nettype wire

// File: rtl/dds_serial_frequency_loader.sv
// top level of the dds serial frequency loader
// usage:
//   slave channel s_*: one request per handshake; tuser selects a frequency load
//   or the reset start-up sequence, tdata carries the frequency in hertz
//   master channel m_*: one strobe event per handshake; tlast marks the final
//   strobe of a request (the update pulse)
// a load gives 41 strobes (32 word bits lsb first, 8 zero control bits, update),
// a reset request gives 3 strobes (reset, word clock, update), all with data 0
// path: the first strobe of a load passes the reciprocal multiply, estimate,
// check and correction steps, then the queue, serialiser and output register;
// a reset request skips the divider steps and goes straight to the queue
// throughput: one strobe per cycle at most; a load occupies the serialiser for
// all 41 strobes and the front end only for its divider steps, so the serialiser paces loads
// the front end works on the next request while the serialiser still emits
// the previous one, a two-entry queue sitting between them
// when the receiver stalls the output register holds its strobe and the
// queue fills, after which s_tready drops
// reset clears all control state, queue and output register empty
`default_nettype none

module dds_serial_frequency_loader #(
    parameter int unsigned REF_CLOCK_HZ = dsfl_pkg::REF_CLOCK_HZ_DEFAULT
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output      logic        s_tready,
    input  wire logic [31:0] s_tdata,   // [25:0] frequency_hz, rest zero
    input  wire logic [0:0]  s_tuser,   // [0] action
    output      logic        m_tvalid,
    input  wire logic        m_tready,
    output      logic [7:0]  m_tdata,   // [0] data_bit, rest zero
    output      logic [1:0]  m_tuser,   // [1:0] strobe_res
    output      logic        m_tlast
);

    logic             push_valid;
    logic             push_ready;
    dsfl_pkg::entry_t push_entry;
    logic             pop_valid;
    logic             pop_ready;
    dsfl_pkg::entry_t pop_entry;
    logic             out_bit;

    dsfl_front #(
        .REF_CLOCK_HZ (REF_CLOCK_HZ)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_action  (s_tuser[0]),
        .in_freq    (s_tdata[dsfl_pkg::FREQ_W-1:0]),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry)
    );

    dsfl_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (push_valid),
        .wr_ready (push_ready),
        .wr_entry (push_entry),
        .rd_valid (pop_valid),
        .rd_ready (pop_ready),
        .rd_entry (pop_entry)
    );

    dsfl_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (pop_valid),
        .q_ready    (pop_ready),
        .q_entry    (pop_entry),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_bit    (out_bit),
        .out_strobe (m_tuser),
        .out_last   (m_tlast)
    );

    assign m_tdata = {7'b0, out_bit};

endmodule

`default_nettype wire

// File: test/dds_serial_frequency_loader_test.sv
// self-checking stream testbench for the dds serial frequency loader
`timescale 1ns / 100ps

module dds_serial_frequency_loader_test;

    localparam int unsigned CYCLE_LIMIT   = 500000;
    localparam int unsigned RANDOM_COUNT  = 193;
    localparam int unsigned CALM_FROM     = 165;
    localparam int unsigned DRAIN_CYCLES  = 100;
    localparam logic [63:0] REF_HZ        = 64'(dsfl_pkg::REF_CLOCK_HZ_DEFAULT);
    localparam logic [63:0] HALF_REF_HZ   = REF_HZ / 2;
    localparam logic [25:0] FREQ_MAX      = 26'h3FFFFFF;
    localparam logic [25:0] FREQ_HALF     = 26'(HALF_REF_HZ);
    localparam int unsigned DIRECTED_ROWS = 17;

    typedef struct packed {
        logic              data_bit;
        dsfl_pkg::strobe_t strobe;
        logic              last;
    } strobe_event_t;

    typedef struct packed {
        dsfl_pkg::action_t action;
        logic [25:0]       freq;
        logic              word_known;
        logic [31:0]       word;
    } request_row_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;   // [25:0] frequency_hz, rest zero
    logic [0:0]  s_tuser;   // [0] action
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;   // [0] data_bit, rest zero
    logic [1:0]  m_tuser;   // [1:0] strobe_res
    logic        m_tlast;

    strobe_event_t pending_strobes[$];
    int unsigned   errors          = 0;
    int unsigned   cycle_count     = 0;
    int unsigned   loads_sent      = 0;
    int unsigned   resets_sent     = 0;
    int unsigned   saturated_loads = 0;
    int unsigned   strobes_checked = 0;
    logic          calm            = 1'b0;
    logic          quiet_stretch   = 1'b0;

    // expected tuning word for a load; word is typed in only where obvious
    request_row_t directed_rows [DIRECTED_ROWS] = '{
        '{dsfl_pkg::ACT_RESET, 26'd0,        1'b0, 32'd0},
        '{dsfl_pkg::ACT_LOAD,  26'd0,        1'b1, 32'h0000_0000},
        '{dsfl_pkg::ACT_LOAD,  26'd1,        1'b1, 32'd34},
        '{dsfl_pkg::ACT_LOAD,  FREQ_HALF,    1'b1, 32'h8000_0000},
        '{dsfl_pkg::ACT_LOAD,  FREQ_HALF + 26'd1, 1'b1, 32'h8000_0000},
        '{dsfl_pkg::ACT_LOAD,  FREQ_MAX,     1'b1, 32'h8000_0000},
        '{dsfl_pkg::ACT_LOAD,  26'd31250000, 1'b1, 32'h4000_0000},
        '{dsfl_pkg::ACT_RESET, FREQ_MAX,     1'b0, 32'd0},
        '{dsfl_pkg::ACT_LOAD,  FREQ_HALF - 26'd1, 1'b0, 32'd0},
        '{dsfl_pkg::ACT_LOAD,  26'h2AAAAAA,  1'b0, 32'd0},
        '{dsfl_pkg::ACT_LOAD,  26'h1555555,  1'b0, 32'd0},
        '{dsfl_pkg::ACT_LOAD,  26'h2000000,  1'b0, 32'd0},
        '{dsfl_pkg::ACT_RESET, 26'h1555555,  1'b0, 32'd0},
        '{dsfl_pkg::ACT_RESET, 26'd0,        1'b0, 32'd0},
        '{dsfl_pkg::ACT_LOAD,  26'd10000000, 1'b0, 32'd0},
        '{dsfl_pkg::ACT_LOAD,  26'd12345678, 1'b0, 32'd0},
        '{dsfl_pkg::ACT_LOAD,  26'd2,        1'b0, 32'd0}
    };

    dds_serial_frequency_loader i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #5 clk = ~clk;

    // floor(f * 2^32 / ref) with f clipped to half the reference clock
    function automatic logic [31:0] tuning_word(input logic [25:0] freq);
        logic [63:0] f;
        f = 64'(freq);
        if (f > HALF_REF_HZ)
            f = HALF_REF_HZ;
        return 32'((f << 32) / REF_HZ);
    endfunction

    task automatic push_load_strobes(input logic [31:0] word);
        for (int i = 0; i < int'(dsfl_pkg::WORD_W); i++)
            pending_strobes.push_back('{word[i], dsfl_pkg::STROBE_WCLK, 1'b0});
        for (int i = 0; i < int'(dsfl_pkg::CTRL_BITS); i++)
            pending_strobes.push_back('{1'b0, dsfl_pkg::STROBE_WCLK, 1'b0});
        pending_strobes.push_back('{1'b0, dsfl_pkg::STROBE_FQUD, 1'b1});
    endtask

    task automatic push_reset_strobes();
        pending_strobes.push_back('{1'b0, dsfl_pkg::STROBE_RST, 1'b0});
        pending_strobes.push_back('{1'b0, dsfl_pkg::STROBE_WCLK, 1'b0});
        pending_strobes.push_back('{1'b0, dsfl_pkg::STROBE_FQUD, 1'b1});
    endtask

    // offer one request, hold it until taken, then maybe leave a gap
    task automatic send_request(input dsfl_pkg::action_t action, input logic [25:0] freq,
                                input logic word_known, input logic [31:0] word);
        s_tvalid <= 1'b1;
        s_tuser  <= action;
        s_tdata  <= {6'b0, freq};
        do
            @(posedge clk);
        while (!s_tready);
        if (action == dsfl_pkg::ACT_RESET)
        begin
            push_reset_strobes();
            resets_sent++;
        end
        else
        begin
            push_load_strobes(word_known ? word : tuning_word(freq));
            loads_sent++;
            if (64'(freq) > HALF_REF_HZ)
                saturated_loads++;
        end
        if (!calm && !quiet_stretch && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_strobes.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [25:0] random_frequency();
        case ($urandom_range(0, 9))
            0:       return 26'($urandom_range(0, 32'(FREQ_MAX)));
            1:       return 26'($urandom_range(32'(FREQ_HALF) - 4, 32'(FREQ_HALF) + 4));
            2:       return 26'($urandom_range(0, 255));
            default: return 26'($urandom_range(0, 32'(FREQ_HALF)));
        endcase
    endfunction

    // receiver: random stall bursts
    initial
    begin
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && !calm && !quiet_stretch && $urandom_range(0, 4) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge clk);
            end
            m_tready <= rst_n;
        end
    end

    // checker on the strobe stream
    always @(posedge clk)
    begin
        strobe_event_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_strobes.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected strobe, expected none, actual tdata=%h tuser=%0d tlast=%b",
                         $time, m_tdata, m_tuser, m_tlast);
            end
            else
            begin
                want = pending_strobes.pop_front();
                strobes_checked++;
                if (m_tdata !== {7'b0, want.data_bit})
                begin
                    errors++;
                    $display("%0t: data mismatch expected %h actual %h",
                             $time, {7'b0, want.data_bit}, m_tdata);
                end
                if (m_tuser !== want.strobe)
                begin
                    errors++;
                    $display("%0t: strobe kind mismatch expected %0d actual %0d",
                             $time, want.strobe, m_tuser);
                end
                if (m_tlast !== want.last)
                begin
                    errors++;
                    $display("%0t: last mismatch expected %b actual %b",
                             $time, want.last, m_tlast);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t: timeout with %0d strobes outstanding",
                     $time, pending_strobes.size());
            $display("dds_serial_frequency_loader_test: FAIL");
            $finish;
        end
    end

    initial
    begin
        dsfl_pkg::action_t act;
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= dsfl_pkg::ACT_LOAD;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        foreach (directed_rows[i])
            send_request(directed_rows[i].action, directed_rows[i].freq,
                         directed_rows[i].word_known, directed_rows[i].word);
        wait_drained();

        for (int i = 0; i < int'(RANDOM_COUNT); i++)
        begin
            if (i % 16 == 0)
                quiet_stretch = ($urandom_range(0, 2) == 0);
            // hold off once mid-run until the loader has gone quiet
            if (i == int'(RANDOM_COUNT) / 2)
                wait_drained();
            if (i >= int'(CALM_FROM))
                calm = 1'b1;
            act = ($urandom_range(0, 99) < 15) ? dsfl_pkg::ACT_RESET : dsfl_pkg::ACT_LOAD;
            send_request(act, random_frequency(), 1'b0, 32'd0);
        end
        s_tvalid <= 1'b0;

        while (pending_strobes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d loads (%0d clipped at half the reference) and %0d resets",
                 loads_sent, saturated_loads, resets_sent);
        $display("%0d strobes checked, %0d mismatches", strobes_checked, errors);
        if (errors == 0)
            $display("dds_serial_frequency_loader_test: PASS");
        else
            $display("dds_serial_frequency_loader_test: FAIL");
        $finish;
    end

endmodule
